>>> design/luma_quarter_pel_interpolator_core_macros.svh
// Assertion helpers used by the checker module.
`ifndef LUMA_QUARTER_PEL_INTERPOLATOR_CORE_MACROS_SVH
`define LUMA_QUARTER_PEL_INTERPOLATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LQPI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset
`define LQPI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> design/lqpi_pkg.sv
package lqpi_pkg;

	localparam int LANES         = 8;
	localparam int PIXEL_BITS    = 8;
	localparam int PIX_MAX       = (1 << PIXEL_BITS) - 1;
	localparam int MAX_BLOCK_DEF = 16;
	localparam int TAPS          = 6;
	localparam int HALF_LAG      = 5;   // window rows ahead of the first block row

	// port packing
	localparam int IN_DATA_W  = 80;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 72;
	localparam int ROW_W      = 5;
	localparam int WORD_W     = 2;
	localparam int OROW_W     = 4;
	localparam int WORD_BITS  = LANES * PIXEL_BITS;

	// filter arithmetic widths
	localparam int FILT_W = 21;
	localparam int HRAW_W = 15;

	typedef enum logic [1:0] {
		ACT_LOAD_REF  = 2'd0,
		ACT_LOAD_PRED = 2'd1,
		ACT_COMPUTE   = 2'd2
	} action_t;

	// per-word tag travelling alongside the datapath
	typedef struct packed {
		logic              vld;
		logic [OROW_W-1:0] row;
		logic              word;
		logic              last;
	} tag_t;

	function automatic logic signed [FILT_W-1:0] px(input logic [PIXEL_BITS-1:0] p);
		return $signed({{(FILT_W-PIXEL_BITS){1'b0}}, p});
	endfunction

	function automatic logic signed [FILT_W-1:0] sx_hraw(input logic [HRAW_W-1:0] h);
		return $signed({{(FILT_W-HRAW_W){h[HRAW_W-1]}}, h});
	endfunction

	// 6-tap (1,-5,20,20,-5,1) with shifts and adds
	function automatic logic signed [FILT_W-1:0] filt6(
		input logic signed [FILT_W-1:0] a, b, c, d, e, f);
		logic signed [FILT_W-1:0] outer, mid, inner;
		outer = a + f;
		mid   = b + e;
		inner = c + d;
		return outer - ((mid <<< 2) + mid) + ((inner <<< 4) + (inner <<< 2));
	endfunction

	function automatic logic [PIXEL_BITS-1:0] clip_pix(input logic signed [FILT_W-1:0] v);
		logic [PIXEL_BITS-1:0] r;
		if (v < 0)
			r = '0;
		else if (v > $signed(FILT_W'(PIX_MAX)))
			r = PIXEL_BITS'(PIX_MAX);
		else
			r = v[PIXEL_BITS-1:0];
		return r;
	endfunction

	function automatic logic [PIXEL_BITS-1:0] rnd_avg(input logic [PIXEL_BITS-1:0] a,
		input logic [PIXEL_BITS-1:0] b);
		logic [PIXEL_BITS:0] s;
		s = {1'b0, a} + {1'b0, b} + {{PIXEL_BITS{1'b0}}, 1'b1};
		return s[PIXEL_BITS:1];
	endfunction

endpackage

>>> design/lqpi_lane.sv
// One output column: 6x6 pixel patch in, one quarter-pel sample out, two stages.
module lqpi_lane (
	input  logic clk,
	input  logic en,
	input  logic [lqpi_pkg::TAPS-1:0][lqpi_pkg::TAPS*lqpi_pkg::PIXEL_BITS-1:0] patch,
	input  logic [1:0] frac_x,
	input  logic [1:0] frac_y,
	output logic [lqpi_pkg::PIXEL_BITS-1:0] pix_s2
);

	localparam int PB = lqpi_pkg::PIXEL_BITS;
	localparam int HW = lqpi_pkg::HRAW_W;
	localparam int FW = lqpi_pkg::FILT_W;

	logic [lqpi_pkg::TAPS-1:0][HW-1:0] hraw_c, hraw_s1;
	logic [HW-1:0] vraw0_c, vraw1_c, vraw0_s1, vraw1_s1;
	logic [PB-1:0] f22_s1, f23_s1, f32_s1;

	// stage A: horizontal raw sums per row, vertical raw sums on two columns
	always_comb begin
		for (int r = 0; r < lqpi_pkg::TAPS; r++) begin
			hraw_c[r] = HW'(lqpi_pkg::filt6(
				lqpi_pkg::px(patch[r][0*PB +: PB]), lqpi_pkg::px(patch[r][1*PB +: PB]),
				lqpi_pkg::px(patch[r][2*PB +: PB]), lqpi_pkg::px(patch[r][3*PB +: PB]),
				lqpi_pkg::px(patch[r][4*PB +: PB]), lqpi_pkg::px(patch[r][5*PB +: PB])));
		end
		vraw0_c = HW'(lqpi_pkg::filt6(
			lqpi_pkg::px(patch[0][2*PB +: PB]), lqpi_pkg::px(patch[1][2*PB +: PB]),
			lqpi_pkg::px(patch[2][2*PB +: PB]), lqpi_pkg::px(patch[3][2*PB +: PB]),
			lqpi_pkg::px(patch[4][2*PB +: PB]), lqpi_pkg::px(patch[5][2*PB +: PB])));
		vraw1_c = HW'(lqpi_pkg::filt6(
			lqpi_pkg::px(patch[0][3*PB +: PB]), lqpi_pkg::px(patch[1][3*PB +: PB]),
			lqpi_pkg::px(patch[2][3*PB +: PB]), lqpi_pkg::px(patch[3][3*PB +: PB]),
			lqpi_pkg::px(patch[4][3*PB +: PB]), lqpi_pkg::px(patch[5][3*PB +: PB])));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hraw_s1  <= hraw_c;
			vraw0_s1 <= vraw0_c;
			vraw1_s1 <= vraw1_c;
			f22_s1   <= patch[2][2*PB +: PB];
			f23_s1   <= patch[2][3*PB +: PB];
			f32_s1   <= patch[3][2*PB +: PB];
		end
	end

	// stage B: round, clip and pick the sample for this fraction
	logic signed [FW-1:0] ctr_raw, ctr_sh, hh0_sh, hh1_sh, vh0_sh, vh1_sh;
	logic [PB-1:0] ctr, hh0, hh1, vh0, vh1, sel;

	always_comb begin
		ctr_raw = lqpi_pkg::filt6(
			lqpi_pkg::sx_hraw(hraw_s1[0]), lqpi_pkg::sx_hraw(hraw_s1[1]),
			lqpi_pkg::sx_hraw(hraw_s1[2]), lqpi_pkg::sx_hraw(hraw_s1[3]),
			lqpi_pkg::sx_hraw(hraw_s1[4]), lqpi_pkg::sx_hraw(hraw_s1[5]));
		ctr_sh = (ctr_raw + FW'(512)) >>> 10;
		hh0_sh = (lqpi_pkg::sx_hraw(hraw_s1[2]) + FW'(16)) >>> 5;
		hh1_sh = (lqpi_pkg::sx_hraw(hraw_s1[3]) + FW'(16)) >>> 5;
		vh0_sh = (lqpi_pkg::sx_hraw(vraw0_s1) + FW'(16)) >>> 5;
		vh1_sh = (lqpi_pkg::sx_hraw(vraw1_s1) + FW'(16)) >>> 5;
		ctr = lqpi_pkg::clip_pix(ctr_sh);
		hh0 = lqpi_pkg::clip_pix(hh0_sh);
		hh1 = lqpi_pkg::clip_pix(hh1_sh);
		vh0 = lqpi_pkg::clip_pix(vh0_sh);
		vh1 = lqpi_pkg::clip_pix(vh1_sh);

		if (frac_y == 2'd0) begin
			if (frac_x == 2'd0)
				sel = f22_s1;
			else if (frac_x == 2'd2)
				sel = hh0;
			else
				sel = lqpi_pkg::rnd_avg(hh0, (frac_x == 2'd3) ? f23_s1 : f22_s1);
		end else if (frac_x == 2'd0) begin
			if (frac_y == 2'd2)
				sel = vh0;
			else
				sel = lqpi_pkg::rnd_avg(vh0, (frac_y == 2'd3) ? f32_s1 : f22_s1);
		end else if (frac_y == 2'd2) begin
			if (frac_x == 2'd2)
				sel = ctr;
			else
				sel = lqpi_pkg::rnd_avg(ctr, (frac_x == 2'd3) ? vh1 : vh0);
		end else if (frac_x == 2'd2) begin
			sel = lqpi_pkg::rnd_avg(ctr, (frac_y == 2'd3) ? hh1 : hh0);
		end else begin
			// diagonal quarter positions
			sel = lqpi_pkg::rnd_avg((frac_y == 2'd3) ? hh1 : hh0,
				(frac_x == 2'd3) ? vh1 : vh0);
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			pix_s2 <= sel;
	end

endmodule

>>> design/lqpi_merge.sv
// Joins the lane samples, applies prediction averaging, holds the output transaction.
module lqpi_merge (
	input  logic clk,
	input  logic arst_n,
	input  lqpi_pkg::tag_t tag_s4,
	input  logic [lqpi_pkg::WORD_BITS-1:0] lane_pix,
	input  logic [lqpi_pkg::WORD_BITS-1:0] pred,
	input  logic avg_en,
	output logic adv,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [lqpi_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // out_row[3:0], out_word, out_pixels
	output logic m_axis_tlast                             // last
);

	localparam int PB = lqpi_pkg::PIXEL_BITS;
	localparam int WB = lqpi_pkg::WORD_BITS;
	localparam int OR = lqpi_pkg::OROW_W;

	logic [WB-1:0] merged;
	logic          vld_q;
	logic [OR-1:0] row_q;
	logic          word_q;
	logic          last_q;
	logic [WB-1:0] pix_q;

	// whole pipeline moves when the output register is free
	assign adv = !vld_q || m_axis_tready;

	// optional rounded average with the stored prediction
	always_comb begin
		for (int k = 0; k < lqpi_pkg::LANES; k++) begin
			merged[k*PB +: PB] = avg_en ?
				lqpi_pkg::rnd_avg(lane_pix[k*PB +: PB], pred[k*PB +: PB]) :
				lane_pix[k*PB +: PB];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= tag_s4.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tag_s4.vld) begin
			row_q  <= tag_s4.row;
			word_q <= tag_s4.word;
			last_q <= tag_s4.last;
			pix_q  <= merged;
		end
	end

	assign m_axis_tvalid = vld_q;
	assign m_axis_tlast  = last_q;
	assign m_axis_tdata  = {{(lqpi_pkg::OUT_DATA_W-OR-1-WB){1'b0}}, pix_q, word_q, row_q};

endmodule

>>> design/luma_quarter_pel_interpolator_core.sv
// Luma quarter-pel interpolator (8-bit, H.264 rules). Load the reference window
// (MAX_BLOCK+5 rows of 8-pixel words) and, when averaging, the prediction words,
// one load transaction per cycle while no compute is running; then send one compute
// transaction. Results come out column group first, rows inner, one 8-pixel word per
// transaction, tlast on the final word. The window memory is read on two ports, one
// row of two words a cycle while the output is not stalled, into a six-row shift
// window that eight filter lanes share; each column group refills that window, so a
// compute reads size+5 window rows per group. The next input is taken once the
// pipeline has drained into the output register.
// Reading window or prediction words never loaded returns undefined pixels.
module luma_quarter_pel_interpolator_core #(
	parameter int MAX_BLOCK = lqpi_pkg::MAX_BLOCK_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// row[4:0], word[6:5], pixels[70:7], frac_x[72:71], frac_y[74:73],
	// block_is_16[75], average[76]
	input  logic [lqpi_pkg::IN_DATA_W-1:0] s_axis_tdata,
	input  logic [lqpi_pkg::IN_USER_W-1:0] s_axis_tuser,   // action
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [lqpi_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // out_row[3:0], out_word, out_pixels
	output logic m_axis_tlast                             // last
);

	localparam int LANES      = lqpi_pkg::LANES;
	localparam int PB         = lqpi_pkg::PIXEL_BITS;
	localparam int WB         = lqpi_pkg::WORD_BITS;
	localparam int TAPS       = lqpi_pkg::TAPS;
	localparam int WIN_ROWS   = MAX_BLOCK + 5;
	localparam int WIN_WORDS  = (MAX_BLOCK + 5 + LANES - 1) / LANES;
	localparam int PRED_WORDS = MAX_BLOCK / LANES;
	localparam int WIN_DEPTH  = WIN_ROWS * WIN_WORDS;
	localparam int PRED_DEPTH = MAX_BLOCK * PRED_WORDS;
	localparam int WA_W       = $clog2(WIN_DEPTH);
	localparam int PA_W       = $clog2(PRED_DEPTH);
	localparam int RR_W       = $clog2(WIN_ROWS);
	localparam int RW         = lqpi_pkg::ROW_W;
	localparam int WW         = lqpi_pkg::WORD_W;
	localparam int OR         = lqpi_pkg::OROW_W;

	// input fields
	lqpi_pkg::action_t in_action;
	logic [RW-1:0]     in_row;
	logic [WW-1:0]     in_word;
	logic [WB-1:0]     in_pixels;
	logic [1:0]        in_fx, in_fy;
	logic              in_b16, in_avg;

	assign in_action = lqpi_pkg::action_t'(s_axis_tuser);
	assign in_row    = s_axis_tdata[4:0];
	assign in_word   = s_axis_tdata[6:5];
	assign in_pixels = s_axis_tdata[70:7];
	assign in_fx     = s_axis_tdata[72:71];
	assign in_fy     = s_axis_tdata[74:73];
	assign in_b16    = s_axis_tdata[75];
	assign in_avg    = s_axis_tdata[76];

	logic in_acc, adv;
	logic ref_we, pred_we, cmp_go;

	assign in_acc = s_axis_tvalid && s_axis_tready;

	// decode the transaction kind
	always_comb begin
		ref_we  = 1'b0;
		pred_we = 1'b0;
		cmp_go  = 1'b0;
		case (in_action)
			lqpi_pkg::ACT_LOAD_REF:
				ref_we = in_acc && (in_row < RW'(WIN_ROWS)) && (in_word < WW'(WIN_WORDS));
			lqpi_pkg::ACT_LOAD_PRED:
				pred_we = in_acc && (in_row < RW'(MAX_BLOCK)) && (in_word < WW'(PRED_WORDS));
			lqpi_pkg::ACT_COMPUTE:
				cmp_go = in_acc;
			default: ;
		endcase
	end

	// compute sequencer: window row counter inside column group counter
	logic            busy_q, sz16_q, g_q, avg_q;
	logic [RR_W-1:0] rr_q, rr_last;
	logic [1:0]      fx_q, fy_q;
	logic            g_last, row_end;

	assign rr_last = sz16_q ? RR_W'(MAX_BLOCK + 4) : RR_W'(LANES + 4);
	assign g_last  = sz16_q;
	assign row_end = (rr_q == rr_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rr_q   <= '0;
			g_q    <= 1'b0;
			sz16_q <= 1'b0;
			avg_q  <= 1'b0;
			fx_q   <= '0;
			fy_q   <= '0;
		end else if (cmp_go) begin
			busy_q <= 1'b1;
			rr_q   <= '0;
			g_q    <= 1'b0;
			sz16_q <= in_b16 && (MAX_BLOCK >= 2 * LANES);
			avg_q  <= in_avg;
			fx_q   <= in_fx;
			fy_q   <= in_fy;
		end else if (busy_q && adv) begin
			if (row_end) begin
				rr_q <= '0;
				if (g_q == g_last)
					busy_q <= 1'b0;
				else
					g_q <= 1'b1;
			end else begin
				rr_q <= rr_q + 1'b1;
			end
		end
	end

	// reference window memory, two read ports
	logic [WB-1:0]   win_mem [WIN_DEPTH];
	logic [WB-1:0]   rd0_s1, rd1_s1;
	logic [WA_W-1:0] ref_wa, ra0, ra1;

	assign ref_wa = WA_W'(in_row * WIN_WORDS + in_word);
	assign ra0    = WA_W'(rr_q * WIN_WORDS + g_q);
	assign ra1    = WA_W'(rr_q * WIN_WORDS + g_q + 1);

	always_ff @(posedge clk) begin
		if (ref_we)
			win_mem[ref_wa] <= in_pixels;
		if (adv) begin
			rd0_s1 <= win_mem[ra0];
			rd1_s1 <= win_mem[ra1];
		end
	end

	// tag pipeline
	logic           rd_vld_s1;
	lqpi_pkg::tag_t tag_s1, tag_s2, tag_s3, tag_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			tag_s1    <= '0;
			tag_s2    <= '0;
			tag_s3    <= '0;
			tag_s4    <= '0;
		end else if (adv) begin
			rd_vld_s1   <= busy_q;
			tag_s1.vld  <= busy_q && (rr_q >= RR_W'(lqpi_pkg::HALF_LAG));
			tag_s1.row  <= OR'(rr_q - RR_W'(lqpi_pkg::HALF_LAG));
			tag_s1.word <= g_q;
			tag_s1.last <= row_end && (g_q == g_last);
			tag_s2      <= tag_s1;
			tag_s3      <= tag_s2;
			tag_s4      <= tag_s3;
		end
	end

	// six-row sliding window, two words wide
	logic [TAPS-1:0][2*WB-1:0] win_s2;

	always_ff @(posedge clk) begin
		if (adv && rd_vld_s1) begin
			for (int r = 0; r < TAPS - 1; r++)
				win_s2[r] <= win_s2[r+1];
			win_s2[TAPS-1] <= {rd1_s1, rd0_s1};
		end
	end

	// filter lanes
	logic [WB-1:0] lane_pix;

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		logic [TAPS-1:0][TAPS*PB-1:0] patch;

		always_comb begin
			for (int r = 0; r < TAPS; r++)
				patch[r] = win_s2[r][k*PB +: TAPS*PB];
		end

		lqpi_lane u_lane (
			.clk    (clk),
			.en     (adv),
			.patch  (patch),
			.frac_x (fx_q),
			.frac_y (fy_q),
			.pix_s2 (lane_pix[k*PB +: PB])
		);
	end

	// prediction memory, read alongside the second lane stage
	logic [WB-1:0]   pred_mem [PRED_DEPTH];
	logic [WB-1:0]   pred_s4;
	logic [PA_W-1:0] pred_wa, pred_ra;

	assign pred_wa = PA_W'(in_row * PRED_WORDS + in_word);
	assign pred_ra = PA_W'(tag_s3.row * PRED_WORDS + tag_s3.word);

	always_ff @(posedge clk) begin
		if (pred_we)
			pred_mem[pred_wa] <= in_pixels;
		if (adv)
			pred_s4 <= pred_mem[pred_ra];
	end

	lqpi_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.tag_s4        (tag_s4),
		.lane_pix      (lane_pix),
		.pred          (pred_s4),
		.avg_en        (avg_q),
		.adv           (adv),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	assign s_axis_tready = !busy_q && !rd_vld_s1 && !tag_s2.vld && !tag_s3.vld
		&& !tag_s4.vld;

endmodule

>>> design/lqpi_checker.sv
`include "luma_quarter_pel_interpolator_core_macros.svh"

// Port-level checks on the interpolator.
module lqpi_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic [lqpi_pkg::IN_DATA_W-1:0] s_axis_tdata,
	input logic [lqpi_pkg::IN_USER_W-1:0] s_axis_tuser,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [lqpi_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic m_axis_tlast
);

	logic cmp_acc, out_hold, out_last;

	assign cmp_acc  = s_axis_tvalid && s_axis_tready
		&& (s_axis_tuser == lqpi_pkg::ACT_COMPUTE);
	assign out_hold = m_axis_tvalid && !m_axis_tready;
	assign out_last = m_axis_tvalid && m_axis_tlast;

	// stalled output transaction stays put
	`LQPI_ASSERT_NEXT(a_out_hold, clk, arst_n, out_hold, m_axis_tvalid && $stable(m_axis_tdata))

	// a compute transaction blocks input for at least the next cycle
	`LQPI_ASSERT_NEXT(a_cmp_busy, clk, arst_n, cmp_acc, !s_axis_tready)

	// final word sits on the bottom row of an 8x8 or 16x16 block
	`LQPI_ASSERT_IMPL(a_last_row, clk, arst_n, out_last, m_axis_tdata[3:0] == 4'd7 || m_axis_tdata[3:0] == 4'd15)

endmodule

bind luma_quarter_pel_interpolator_core lqpi_checker u_lqpi_checker (.*);
